### hw/rtl/i2a_pkg.sv
// Shared types and constants for the integer to ASCII radix converter.
package i2a_pkg;

    typedef enum logic [1:0] {
        REQ_DEC = 2'd0,
        REQ_OCT = 2'd1,
        REQ_BIN = 2'd2,
        REQ_RSV = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CONV = 2'd1,
        ST_SIGN = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [5:0] ASCII_ONE   = 6'd49;
    localparam logic [5:0] ASCII_MINUS = 6'd45;

endpackage

### hw/rtl/integer_to_ascii_radix_core.sv
// Top level of the integer to ASCII radix converter.
//
// Input channel (s_*): one item holds a signed VALUE_WIDTH-bit value in s_tdata
// and the request kind in s_tuser (decimal, octal, binary; the reserved code
// acts as decimal). Output channel (m_*): one ASCII character per item in
// m_tdata, most significant first, no leading zeros, m_tlast on the final one.
// A negative value opens with '-' in decimal and with '1' in octal or binary.
// One number is converted at a time; s_tready is high only while idle.
// Decimal runs a bit-serial double-dabble pass over the magnitude register
// (3*ceil(VALUE_WIDTH/3) bits, 33 at the default width), one bit per cycle,
// then walks the BCD digits one per cycle while the receiver is not stalling.
// Octal and binary walk the magnitude one digit per cycle while the receiver
// is not stalling; a negative value adds a sign character before the digits.
// Leading zero digits are stepped past without presenting a character.
// A stalled receiver holds the current character and freezes the walk.
// Reset returns the block to idle and drops any number in progress.
module integer_to_ascii_radix_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [VALUE_WIDTH-1:0] value, zero fill to whole bytes
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [5:0] char_out, [7:6] zero
    output logic [7:0]                             m_tdata,
    output logic                                   m_tlast
);

    localparam int OW = ((VALUE_WIDTH + 2) / 3) * 3;
    localparam int ND = (VALUE_WIDTH * 302) / 1000 + 1;
    localparam int BW = ND * 4;
    localparam int CW = $clog2(OW + 1);

    i2a_pkg::state_t   state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic              neg_reg, neg_next;
    logic              started_reg, started_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [OW-1:0]     mag_reg, mag_next;
    logic [BW-1:0]     bcd_reg, bcd_next;

    logic [VALUE_WIDTH-1:0] value_in;
    logic [VALUE_WIDTH-1:0] abs_in;
    logic [BW-1:0]     bcd_adj;
    logic              is_dec, is_oct, in_dec;
    logic [3:0]        digit;
    logic              skip;
    logic              accept;
    logic              advance;
    logic [5:0]        char_out;

    assign value_in = s_tdata[VALUE_WIDTH-1:0];
    assign abs_in   = value_in[VALUE_WIDTH-1] ? (~value_in + VALUE_WIDTH'(1)) : value_in;
    assign is_oct   = (mode_reg == i2a_pkg::REQ_OCT);
    assign is_dec   = (mode_reg == i2a_pkg::REQ_DEC) || (mode_reg == i2a_pkg::REQ_RSV);
    assign in_dec   = (s_tuser == i2a_pkg::REQ_DEC) || (s_tuser == i2a_pkg::REQ_RSV);

    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < ND; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
        end
    end

    always_comb
    begin
        if (is_dec)
        begin
            digit = bcd_reg[BW-1 -: 4];
        end
        else if (is_oct)
        begin
            digit = {1'b0, mag_reg[OW-1 -: 3]};
        end
        else
        begin
            digit = {3'b000, mag_reg[OW-1]};
        end
    end

    assign skip    = !started_reg && (digit == 4'd0) && (cnt_reg != CW'(1));
    assign accept  = s_tvalid && s_tready;
    assign advance = (state_reg == i2a_pkg::ST_EMIT) && (skip || m_tready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_dec)
                    begin
                        state_next = i2a_pkg::ST_CONV;
                    end
                    else if (value_in[VALUE_WIDTH-1])
                    begin
                        state_next = i2a_pkg::ST_SIGN;
                    end
                    else
                    begin
                        state_next = i2a_pkg::ST_EMIT;
                    end
                end
            end
            i2a_pkg::ST_CONV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = neg_reg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_SIGN:
            begin
                if (m_tready)
                begin
                    state_next = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT:
            begin
                if (advance && (cnt_reg == CW'(1)))
                begin
                    state_next = i2a_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tlast  = 1'b0;
        char_out = i2a_pkg::ASCII_ZERO + {2'b00, digit};
        case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            i2a_pkg::ST_SIGN:
            begin
                m_tvalid = 1'b1;
                char_out = is_dec ? i2a_pkg::ASCII_MINUS : i2a_pkg::ASCII_ONE;
            end
            i2a_pkg::ST_EMIT:
            begin
                m_tvalid = !skip;
                m_tlast  = (cnt_reg == CW'(1));
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tdata = {2'b00, char_out};

    // Datapath and counters
    always_comb
    begin
        mode_next    = mode_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        cnt_next     = cnt_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next    = s_tuser;
                    neg_next     = value_in[VALUE_WIDTH-1];
                    started_next = 1'b0;
                    mag_next     = OW'(abs_in);
                    bcd_next     = '0;
                    cnt_next     = (s_tuser == i2a_pkg::REQ_OCT) ? CW'(OW / 3) : CW'(OW);
                end
            end
            i2a_pkg::ST_CONV:
            begin
                bcd_next = {bcd_adj[BW-2:0], mag_reg[OW-1]};
                mag_next = {mag_reg[OW-2:0], 1'b0};
                cnt_next = (cnt_reg == CW'(1)) ? CW'(ND) : cnt_reg - CW'(1);
            end
            i2a_pkg::ST_EMIT:
            begin
                if (advance)
                begin
                    cnt_next     = cnt_reg - CW'(1);
                    started_next = started_reg || !skip;
                    if (is_dec)
                    begin
                        bcd_next = {bcd_reg[BW-5:0], 4'b0000};
                    end
                    else if (is_oct)
                    begin
                        mag_next = {mag_reg[OW-4:0], 3'b000};
                    end
                    else
                    begin
                        mag_next = {mag_reg[OW-2:0], 1'b0};
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= i2a_pkg::ST_IDLE;
            mode_reg    <= i2a_pkg::REQ_DEC;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a character is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("block still ready after taking an item");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("block not idle after final character");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == i2a_pkg::ST_EMIT |-> cnt_reg != '0)
        else $error("digit walk ran past its count");

    a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == i2a_pkg::ST_EMIT && is_dec |-> bcd_reg[BW-1 -: 4] <= 4'd9)
        else $error("decimal digit out of range");
`endif

endmodule

### dv/integer_to_ascii_radix_core_tb.sv
// Self-checking testbench for the integer to ASCII radix converter.
module integer_to_ascii_radix_core_tb;

    localparam int VALUE_WIDTH   = 32;
    localparam int RADIX_DEC     = 10;
    localparam int RADIX_OCT     = 8;
    localparam int RADIX_BIN     = 2;
    localparam int RANDOM_ITEMS  = 135;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } ascii_char_t;

    typedef struct {
        i2a_pkg::req_type_t req;
        logic [31:0]        value;
        string              text;
    } number_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = i2a_pkg::REQ_DEC;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    ascii_char_t pending_chars[$];
    ascii_char_t head_char;
    int          mismatches = 0;
    int          chars_checked = 0;
    int          numbers_sent = 0;
    int          req_seen [4] = '{0, 0, 0, 0};
    int          idle_phase = 0;
    int          cycle_count = 0;
    bit          hold_done = 1'b0;
    int unsigned source_idle_pct [3] = '{26, 50, 0};
    int unsigned sink_idle_pct [3]   = '{50, 26, 0};

    number_row_t directed_rows [DIRECTED_ROWS] = '{
        '{i2a_pkg::REQ_DEC, 32'd0,          "0"},
        '{i2a_pkg::REQ_OCT, 32'd0,          "0"},
        '{i2a_pkg::REQ_BIN, 32'd0,          "0"},
        '{i2a_pkg::REQ_RSV, 32'd0,          "0"},
        '{i2a_pkg::REQ_DEC, 32'd1,          "1"},
        '{i2a_pkg::REQ_DEC, 32'hFFFF_FFFF,  "-1"},
        '{i2a_pkg::REQ_OCT, 32'hFFFF_FFFF,  "11"},
        '{i2a_pkg::REQ_BIN, 32'hFFFF_FFFF,  "11"},
        '{i2a_pkg::REQ_DEC, 32'h7FFF_FFFF,  "2147483647"},
        '{i2a_pkg::REQ_DEC, 32'h8000_0000,  "-2147483648"},
        '{i2a_pkg::REQ_OCT, 32'h7FFF_FFFF,  "17777777777"},
        '{i2a_pkg::REQ_OCT, 32'h8000_0000,  "120000000000"},
        '{i2a_pkg::REQ_BIN, 32'h7FFF_FFFF,  ""},
        '{i2a_pkg::REQ_BIN, 32'h8000_0000,  ""},
        '{i2a_pkg::REQ_RSV, 32'd12345,      "12345"},
        '{i2a_pkg::REQ_RSV, 32'hFFFF_FFF9,  "-7"},
        '{i2a_pkg::REQ_DEC, 32'd9,          "9"},
        '{i2a_pkg::REQ_DEC, 32'd10,         "10"},
        '{i2a_pkg::REQ_OCT, 32'd7,          "7"},
        '{i2a_pkg::REQ_OCT, 32'd8,          "10"},
        '{i2a_pkg::REQ_BIN, 32'd1,          "1"},
        '{i2a_pkg::REQ_BIN, 32'd2,          "10"},
        '{i2a_pkg::REQ_OCT, 32'hFFFF_FFF8,  "110"},
        '{i2a_pkg::REQ_BIN, 32'h5555_5555,  ""},
        '{i2a_pkg::REQ_DEC, 32'h8000_0001,  ""}
    };

    integer_to_ascii_radix_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void spell_number(input i2a_pkg::req_type_t req,
                                         input logic [31:0] value);
        longint unsigned radix;
        longint unsigned mag;
        longint unsigned place;
        longint unsigned digit;
        logic            negative;
        radix    = (req == i2a_pkg::REQ_OCT) ? RADIX_OCT :
                   (req == i2a_pkg::REQ_BIN) ? RADIX_BIN : RADIX_DEC;
        negative = value[31];
        mag      = negative ? longint'(32'(-value)) : longint'(value);
        if (mag == 0)
        begin
            pending_chars.push_back('{{2'b00, i2a_pkg::ASCII_ZERO}, 1'b1});
            return;
        end
        if (negative)
            pending_chars.push_back('{{2'b00, (radix == RADIX_DEC) ? i2a_pkg::ASCII_MINUS
                                                                   : i2a_pkg::ASCII_ONE},
                                     1'b0});
        place = 1;
        while (place <= mag / radix)
            place = place * radix;
        while (place > 0)
        begin
            digit = mag / place;
            mag   = mag % place;
            place = place / radix;
            pending_chars.push_back('{{2'b00, i2a_pkg::ASCII_ZERO + 6'(digit)}, place == 0});
        end
    endfunction

    function automatic void spell_text(input string text);
        byte ch;
        for (int i = 0; i < text.len(); i++)
        begin
            ch = text[i];
            pending_chars.push_back('{{2'b00, ch[5:0]}, i == text.len() - 1});
        end
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endfunction

    task automatic offer_number(input i2a_pkg::req_type_t req, input logic [31:0] value,
                                input string text);
        while ($urandom_range(0, 99) < source_idle_pct[idle_phase])
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (text.len() != 0)
            spell_text(text);
        else
            spell_number(req, value);
        numbers_sent++;
        req_seen[req]++;
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] value;
        int unsigned shape;
        shape = $urandom_range(0, 3);
        value = $urandom;
        if (shape == 1)
            value = value >> $urandom_range(1, 31);
        else if (shape == 2)
            value = $urandom_range(0, 64);
        if (shape != 0 && $urandom_range(0, 1) == 1)
            value = -value;
        return value;
    endfunction

    initial
    begin : sink_pacing
        forever
        begin
            @(posedge clk);
            if (idle_phase == 2 && !hold_done)
            begin
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct[idle_phase]);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                note_mismatch($sformatf("unexpected character data %h last %b",
                                        m_tdata, m_tlast));
            end
            else
            begin
                head_char = pending_chars.pop_front();
                if (m_tdata !== head_char.data)
                    note_mismatch($sformatf("character expected %h got %h",
                                            head_char.data, m_tdata));
                if (m_tlast !== head_char.last)
                    note_mismatch($sformatf("last expected %b got %b",
                                            head_char.last, m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, pending_chars.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                 item_index;
        i2a_pkg::req_type_t req;
        item_index = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            offer_number(directed_rows[r].req, directed_rows[r].value, directed_rows[r].text);
            item_index++;
        end

        for (int r = 0; r < RANDOM_ITEMS; r++)
        begin
            idle_phase = (item_index < 62) ? 0 : (item_index < 124) ? 1 : 2;
            if ($urandom_range(0, 9) == 0)
                req = i2a_pkg::REQ_RSV;
            else
                req = i2a_pkg::req_type_t'($urandom_range(0, 2));
            offer_number(req, random_value(), "");
            item_index++;
        end
        s_tvalid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers: %0d decimal, %0d octal, %0d binary, %0d reserved",
                 numbers_sent, req_seen[i2a_pkg::REQ_DEC], req_seen[i2a_pkg::REQ_OCT],
                 req_seen[i2a_pkg::REQ_BIN], req_seen[i2a_pkg::REQ_RSV]);
        $display("Checked %0d characters over three pacing phases and one long output stall",
                 chars_checked);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hw/rtl/i2a_pkg.sv
hw/rtl/integer_to_ascii_radix_core.sv
dv/integer_to_ascii_radix_core_tb.sv
